// File: sv/gevt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gevt_pkg
// Shared types, codes and helper functions of the gamepad event translator.
// ----------------------------------------------------------------------------
package gevt_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int MAX_RESULTS = 3;
  localparam int NUM_CAND    = 4;

  // input commands
  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_AXIS    = 2'd2
  } cmd_t;

  // result kinds
  localparam logic [1:0] KIND_DOWN = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_AX   = 2'd2;
  localparam logic [1:0] KIND_AY   = 2'd3;

  // register indexes
  localparam logic [1:0] REG_BUTTON_MAP   = 2'd0;
  localparam logic [1:0] REG_DIGITAL_PAIR = 2'd1;
  localparam logic [1:0] REG_ANALOG_PAIR  = 2'd2;
  localparam logic [1:0] REG_THRESHOLD    = 2'd3;

  localparam logic [47:0] BUTTON_MAP_RST = 48'hFAC688FAC688;
  localparam logic [6:0]  DIGITAL_PAIR_RST = 7'd0;
  localparam logic [7:0]  ANALOG_PAIR_RST  = 8'hFF;
  localparam logic [14:0] THRESHOLD_RST    = 15'd10000;

  // direction pad bits
  localparam logic [15:0] MASK_UP    = 16'h0010;
  localparam logic [15:0] MASK_RIGHT = 16'h0020;
  localparam logic [15:0] MASK_DOWN  = 16'h0040;
  localparam logic [15:0] MASK_LEFT  = 16'h0080;

  localparam logic [15:0] LEVEL_DIV = 16'd65534;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
  } res_t;

  function automatic logic [15:0] slot_mask(input logic [2:0] slot);
    logic [15:0] m;
    unique case (slot)
      3'd0: m = 16'h4000;
      3'd1: m = 16'h2000;
      3'd2: m = 16'h1000;
      3'd3: m = 16'h8000;
      3'd4: m = 16'h0100;
      3'd5: m = 16'h0200;
      3'd6: m = 16'h0008;
      3'd7: m = 16'h0001;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

  // (v + 32767) * 255 / 65534 truncated; the estimate p >> 16 is at most one low
  function automatic logic [7:0] analog_level(input logic signed [15:0] v);
    logic signed [16:0] xs;
    logic [15:0] x;
    logic [23:0] p;
    logic [7:0]  q;
    logic [23:0] r;
    xs = 17'(v) + 17'sd32767;
    x  = xs[16] ? 16'd0 : xs[15:0];
    p  = {x, 8'd0} - {8'd0, x};
    q  = p[23:16];
    r  = p - ({q, 16'd0} - {15'd0, q, 1'b0});
    if (r >= {8'd0, LEVEL_DIV}) begin
      q = q + 8'd1;
    end
    return q;
  endfunction

endpackage

// File: sv/gamepad_event_translator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_event_translator_top
// Turns gamepad button and axis events into controller button and stick events.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  request  | req_valid/req_ready  | command, button_number, axis_number, axis_value
//  result   | rsp_valid/rsp_ready  | event_kind, event_value, last
//  config   | apb psel/penable     | paddr[4:3] selects register, 64-bit data
//
//  a request is held in the input register, then its results (zero to
//  three) are loaded into the result buffer and leave one per cycle while
//  rsp_ready is high.
//  first result appears after passing the input register and the result buffer.
//  reset clears held buttons and loads the register defaults.
//  a stalled result port holds the buffer and, behind it, the input register.
module gamepad_event_translator_top
  import gevt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         command,
  input  logic [7:0]         button_number,
  input  logic [7:0]         axis_number,
  input  logic signed [15:0] axis_value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [1:0]         event_kind,
  output logic [15:0]        event_value,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [47:0] button_map;
  logic [6:0]  digital_axis_pair;
  logic [7:0]  analog_axis_pair;
  logic [14:0] threshold;

  logic [1:0] reg_idx;
  logic       cfg_wr;

  // input register
  logic               s1_valid;
  logic [1:0]         s1_cmd;
  logic [7:0]         s1_button;
  logic [7:0]         s1_axis;
  logic signed [15:0] s1_value;

  // state and result buffer
  logic [15:0] held_buttons;
  logic [15:0] held_next;
  res_t        rbuf [MAX_RESULTS];
  res_t        rbuf_next [MAX_RESULTS];
  logic [1:0]  rcnt;
  logic [1:0]  rcnt_next;

  res_t       cand [NUM_CAND];
  logic [NUM_CAND-1:0] cand_ok;
  res_t       comp [MAX_RESULTS];
  logic [1:0] ncomp;

  logic load_ok;
  logic s1_adv;
  logic pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_BUTTON_MAP:   prdata = {16'd0, button_map};
      REG_DIGITAL_PAIR: prdata = {57'd0, digital_axis_pair};
      REG_ANALOG_PAIR:  prdata = {56'd0, analog_axis_pair};
      REG_THRESHOLD:    prdata = {49'd0, threshold};
      default:          prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_map        <= BUTTON_MAP_RST;
      digital_axis_pair <= DIGITAL_PAIR_RST;
      analog_axis_pair  <= ANALOG_PAIR_RST;
      threshold         <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BUTTON_MAP:   button_map        <= pwdata[47:0];
        REG_DIGITAL_PAIR: digital_axis_pair <= pwdata[6:0];
        REG_ANALOG_PAIR:  analog_axis_pair  <= pwdata[7:0];
        REG_THRESHOLD:    threshold         <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign rsp_valid = (rcnt != 2'd0);
  assign pop       = rsp_valid && rsp_ready;
  assign load_ok   = (rcnt == 2'd0) || ((rcnt == 2'd1) && rsp_ready);
  assign s1_adv    = s1_valid && load_ok;
  assign req_ready = !s1_valid || load_ok;

  assign event_kind  = rbuf[0].kind;
  assign event_value = rbuf[0].value;
  assign last        = (rcnt == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_cmd    <= command;
      s1_button <= button_number;
      s1_axis   <= axis_number;
      s1_value  <= axis_value;
    end
  end

  // translation of the registered request
  always_comb begin
    logic [6:0]         pair;
    logic               vert;
    logic signed [16:0] v17;
    logic signed [16:0] thr;
    logic [15:0]        pos_mask;
    logic [15:0]        neg_mask;
    logic [15:0]        first_rel;
    logic [15:0]        second_rel;
    logic [15:0]        cur;
    logic [15:0]        mask;
    logic [2:0]         slot;
    pair       = s1_axis[7:1];
    vert       = s1_axis[0];
    v17        = 17'(s1_value);
    thr        = signed'({2'b00, threshold});
    pos_mask   = vert ? MASK_DOWN : MASK_RIGHT;
    neg_mask   = vert ? MASK_UP : MASK_LEFT;
    first_rel  = vert ? MASK_UP : MASK_RIGHT;
    second_rel = vert ? MASK_DOWN : MASK_LEFT;
    slot       = button_map[3*s1_button[3:0] +: 3];
    mask       = slot_mask(slot);
    held_next  = held_buttons;
    cur        = 16'd0;
    for (int i = 0; i < NUM_CAND; i++) begin
      cand[i] = '0;
    end
    cand_ok = '0;

    unique case (s1_cmd)
      CMD_PRESS, CMD_RELEASE: begin
        if ({1'b0, s1_button} < 9'(NUM_BUTTONS)) begin
          cand_ok[0] = 1'b1;
          cand[0].value = mask;
          if (s1_cmd == CMD_PRESS) begin
            held_next     = held_buttons | mask;
            cand[0].kind  = KIND_DOWN;
          end else begin
            held_next     = held_buttons & ~mask;
            cand[0].kind  = KIND_UP;
          end
        end
      end
      CMD_AXIS: begin
        if (pair == digital_axis_pair) begin
          if (v17 > thr) begin
            cur = pos_mask;
          end else if (v17 < -thr) begin
            cur = neg_mask;
          end
          if (((held_next & first_rel) != 16'd0) && (cur != first_rel)) begin
            held_next     = held_next & ~first_rel;
            cand_ok[0]    = 1'b1;
            cand[0].kind  = KIND_UP;
            cand[0].value = first_rel;
          end
          if (((held_next & second_rel) != 16'd0) && (cur != second_rel)) begin
            held_next     = held_next & ~second_rel;
            cand_ok[1]    = 1'b1;
            cand[1].kind  = KIND_UP;
            cand[1].value = second_rel;
          end
          if ((cur != 16'd0) && ((held_next & cur) == 16'd0)) begin
            held_next     = held_next | cur;
            cand_ok[2]    = 1'b1;
            cand[2].kind  = KIND_DOWN;
            cand[2].value = cur;
          end
        end
        if (!analog_axis_pair[7] && (analog_axis_pair[6:0] == pair)) begin
          cand_ok[3]    = 1'b1;
          cand[3].kind  = vert ? KIND_AY : KIND_AX;
          cand[3].value = {8'd0, analog_level(s1_value)};
        end
      end
      default: ;
    endcase
  end

  // pack valid results in order, dropping any beyond three
  always_comb begin
    ncomp = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      comp[i] = '0;
    end
    for (int i = 0; i < NUM_CAND; i++) begin
      if (cand_ok[i] && (ncomp != 2'(MAX_RESULTS))) begin
        comp[ncomp] = cand[i];
        ncomp       = ncomp + 2'd1;
      end
    end
  end

  always_comb begin
    rcnt_next = rcnt;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      rbuf_next[i] = rbuf[i];
    end
    if (s1_adv) begin
      rcnt_next = ncomp;
      for (int i = 0; i < MAX_RESULTS; i++) begin
        rbuf_next[i] = comp[i];
      end
    end else if (pop) begin
      rcnt_next = rcnt - 2'd1;
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        rbuf_next[i] = rbuf[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt         <= 2'd0;
      held_buttons <= 16'd0;
    end else begin
      rcnt <= rcnt_next;
      if (s1_adv) begin
        held_buttons <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      rbuf[i] <= rbuf_next[i];
    end
  end

  // opposite pad directions are never held together
  a_no_up_down: assert property (@(posedge clk) disable iff (rst)
    !(held_buttons[4] && held_buttons[6]))
    else $error("up and down held together");

  a_no_left_right: assert property (@(posedge clk) disable iff (rst)
    !(held_buttons[5] && held_buttons[7]))
    else $error("left and right held together");

  a_analog_range: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (event_kind == KIND_AX || event_kind == KIND_AY))
      |-> (event_value[15:8] == 8'd0))
    else $error("analog level out of range");

  a_s1_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !load_ok) |=> s1_valid)
    else $error("pending request dropped");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gamepad event translator: button presses and
// releases through the slot map, direction pad and analog stick axes under
// several register settings, with random stalls on both the request and the
// result channel.
// ----------------------------------------------------------------------------
module testbench
  import gevt_pkg::*;
();

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [15:0] SLOT_BIT [8] = '{16'h4000, 16'h2000, 16'h1000, 16'h8000,
                                           16'h0100, 16'h0200, 16'h0008, 16'h0001};

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] value;
    logic        last;
  } ctrl_event_t;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_ready;
  logic [1:0]         command;
  logic [7:0]         button_number;
  logic [7:0]         axis_number;
  logic signed [15:0] axis_value;
  logic               rsp_valid;
  logic               rsp_ready;
  logic [1:0]         event_kind;
  logic [15:0]        event_value;
  logic               last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;

  // translator state as the bench expects it
  logic [15:0]        held_mask;
  logic [47:0]        map_cfg;
  logic [6:0]         dpad_pair;
  logic signed [7:0]  stick_pair;
  logic [14:0]        dead_zone;

  ctrl_event_t expected_events[$];
  ctrl_event_t fresh_events[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int requests_sent;
  int events_checked;
  int registers_written;

  gamepad_event_translator_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .command       (command),
    .button_number (button_number),
    .axis_number   (axis_number),
    .axis_value    (axis_value),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .event_kind    (event_kind),
    .event_value   (event_value),
    .last          (last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got 0x%0h expected 0x%0h (event %0d)", what, got, want,
             events_checked);
    mismatches++;
  endtask

  function automatic void push_event(input logic [1:0] kind, input logic [15:0] value);
    ctrl_event_t ev;
    ev.kind  = kind;
    ev.value = value;
    ev.last  = 1'b0;
    fresh_events.push_back(ev);
  endfunction

  // release a direction no longer held, then press the new one
  function automatic void pad_direction(input int v, input logic [15:0] pos_bit,
                                        input logic [15:0] neg_bit, input logic [15:0] rel_a,
                                        input logic [15:0] rel_b);
    logic [15:0] cur;
    cur = '0;
    if (v > int'(dead_zone)) cur = pos_bit;
    else if (v < -int'(dead_zone)) cur = neg_bit;
    if ((held_mask & rel_a) != 0 && cur != rel_a) begin
      held_mask &= ~rel_a;
      push_event(KIND_UP, rel_a);
    end
    if ((held_mask & rel_b) != 0 && cur != rel_b) begin
      held_mask &= ~rel_b;
      push_event(KIND_UP, rel_b);
    end
    if (cur != 0 && (held_mask & cur) == 0) begin
      held_mask |= cur;
      push_event(KIND_DOWN, cur);
    end
  endfunction

  function automatic void translate_request(input logic [1:0] cmd, input logic [7:0] btn,
                                            input logic [7:0] axis,
                                            input logic signed [15:0] val);
    logic [15:0] bit_mask;
    logic [6:0]  pair;
    logic        vertical;
    int          level;
    fresh_events.delete();
    if (cmd == CMD_PRESS || cmd == CMD_RELEASE) begin
      if (btn < NUM_BUTTONS) begin
        bit_mask = SLOT_BIT[map_cfg[3*btn +: 3]];
        if (cmd == CMD_PRESS) begin
          held_mask |= bit_mask;
          push_event(KIND_DOWN, bit_mask);
        end else begin
          held_mask &= ~bit_mask;
          push_event(KIND_UP, bit_mask);
        end
      end
    end else if (cmd == CMD_AXIS) begin
      pair     = axis[7:1];
      vertical = axis[0];
      if (pair == dpad_pair) begin
        if (vertical) pad_direction(int'(val), MASK_DOWN, MASK_UP, MASK_UP, MASK_DOWN);
        else pad_direction(int'(val), MASK_RIGHT, MASK_LEFT, MASK_RIGHT, MASK_LEFT);
      end
      if (stick_pair >= 0 && pair == stick_pair[6:0]) begin
        level = ((int'(val) + 32767) * 255) / 65534;
        push_event(vertical ? KIND_AY : KIND_AX, 16'(level));
      end
    end
    if (fresh_events.size() > 0) fresh_events[fresh_events.size() - 1].last = 1'b1;
    foreach (fresh_events[i]) expected_events.push_back(fresh_events[i]);
  endfunction

  always @(posedge clk) begin : check_events
    ctrl_event_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch("event with nothing expected", event_value, 0);
      end else begin
        want = expected_events.pop_front();
        if (event_kind !== want.kind) report_mismatch("event_kind", event_kind, want.kind);
        if (event_value !== want.value) report_mismatch("event_value", event_value, want.value);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
      events_checked++;
    end
  end

  // returns at the accepting edge with valid still up
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] btn,
                              input logic [7:0] axis, input logic [15:0] val);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    req_valid     <= 1'b1;
    command       <= cmd;
    button_number <= btn;
    axis_number   <= axis;
    axis_value    <= val;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    translate_request(cmd, btn, axis, $signed(val));
    requests_sent++;
  endtask

  // stop sending and let every outstanding event drain
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BUTTON_MAP:   map_cfg    = value[47:0];
      REG_DIGITAL_PAIR: dpad_pair  = value[6:0];
      REG_ANALOG_PAIR:  stick_pair = value[7:0];
      REG_THRESHOLD:    dead_zone  = value[14:0];
      default: ;
    endcase
    registers_written++;
  endtask

  task automatic test_buttons_default();
    send_request(CMD_PRESS, 8'd0, 8'd0, 16'h0000);
    send_request(CMD_PRESS, 8'd15, 8'hFF, 16'hFFFF);
    send_request(CMD_RELEASE, 8'd0, 8'd0, 16'h0000);
    send_request(CMD_RELEASE, 8'd15, 8'd0, 16'h0000);
    // out-of-range buttons and the unused command give nothing
    send_request(CMD_PRESS, 8'(NUM_BUTTONS), 8'd0, 16'h0000);
    send_request(CMD_RELEASE, 8'd255, 8'd0, 16'h0000);
    send_request(CMD_UNUSED, 8'd1, 8'd0, 16'h7FFF);
  endtask

  task automatic test_direction_pad();
    send_request(CMD_AXIS, 8'd0, 8'd0, 16'h7FFF);
    send_request(CMD_AXIS, 8'd0, 8'd0, 16'h8000);
    // exactly at the threshold counts as centered
    send_request(CMD_AXIS, 8'd0, 8'd0, 16'(10000));
    send_request(CMD_AXIS, 8'd0, 8'd1, 16'(10001));
    send_request(CMD_AXIS, 8'd0, 8'd1, 16'(-10001));
    send_request(CMD_AXIS, 8'd0, 8'd1, 16'h0000);
    send_request(CMD_AXIS, 8'd0, 8'd2, 16'h7FFF);
  endtask

  task automatic test_stick_and_pad();
    wait_idle();
    write_register(REG_ANALOG_PAIR, 64'd0);
    write_register(REG_THRESHOLD, 64'd0);
    // pad and stick on the same pair, up to three events per request
    send_request(CMD_AXIS, 8'd0, 8'd0, 16'h7FFF);
    send_request(CMD_AXIS, 8'd0, 8'd0, 16'h8000);
    send_request(CMD_AXIS, 8'd0, 8'd1, 16'h0000);
    send_request(CMD_AXIS, 8'd0, 8'd1, 16'hFFFF);
    wait_idle();
    write_register(REG_DIGITAL_PAIR, 64'd127);
    write_register(REG_ANALOG_PAIR, 64'd127);
    write_register(REG_THRESHOLD, 64'd32767);
    send_request(CMD_AXIS, 8'd0, 8'd255, 16'h7FFF);
    send_request(CMD_AXIS, 8'd0, 8'd254, 16'h8000);
    send_request(CMD_AXIS, 8'd0, 8'd254, 16'h0000);
    wait_idle();
    // most negative pair number still disables the stick
    write_register(REG_ANALOG_PAIR, 64'h80);
    send_request(CMD_AXIS, 8'd0, 8'd254, 16'h7FFF);
    send_request(CMD_AXIS, 8'd0, 8'd0, 16'h7FFF);
  endtask

  task automatic test_slot_map();
    wait_idle();
    write_register(REG_BUTTON_MAP, 64'd0);
    send_request(CMD_PRESS, 8'd5, 8'd0, 16'h0000);
    wait_idle();
    write_register(REG_BUTTON_MAP, 64'hFFFF_FFFF_FFFF);
    send_request(CMD_PRESS, 8'd15, 8'd0, 16'h0000);
    send_request(CMD_RELEASE, 8'd15, 8'd0, 16'h0000);
  endtask

  task automatic random_settings();
    logic [47:0] map_word;
    logic [6:0]  dp;
    logic [7:0]  ap;
    logic [14:0] th;
    map_word = {16'($urandom), 32'($urandom)};
    dp = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0:       ap = 8'hFF;
      1:       ap = {1'b0, dp};
      2:       ap = {1'b0, 7'($urandom)};
      default: ap = 8'($urandom_range(128, 255));
    endcase
    case ($urandom_range(0, 4))
      0:       th = 15'd0;
      1:       th = 15'd32767;
      default: th = 15'($urandom_range(0, 20000));
    endcase
    wait_idle();
    write_register(REG_BUTTON_MAP, 64'(map_word));
    write_register(REG_DIGITAL_PAIR, 64'(dp));
    write_register(REG_ANALOG_PAIR, 64'(ap));
    write_register(REG_THRESHOLD, 64'(th));
  endtask

  task automatic random_request();
    int          pick;
    int          v;
    logic [1:0]  cmd;
    logic [7:0]  btn;
    logic [7:0]  axis;
    logic [6:0]  pair;
    logic [15:0] val;
    pick = $urandom_range(0, 99);
    btn  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, NUM_BUTTONS - 1))
                                        : 8'($urandom_range(0, 255));
    axis = 8'($urandom);
    val  = 16'($urandom);
    if (pick < 35) begin
      cmd = $urandom_range(0, 1) ? CMD_PRESS : CMD_RELEASE;
    end else if (pick < 95) begin
      cmd = CMD_AXIS;
      case ($urandom_range(0, 3))
        0, 1:    pair = dpad_pair;
        2:       pair = (stick_pair >= 0) ? stick_pair[6:0] : dpad_pair;
        default: pair = 7'($urandom);
      endcase
      axis = {pair, 1'($urandom)};
      // lean on the extremes and on values around the threshold
      case ($urandom_range(0, 5))
        0:       v = 32767;
        1:       v = -32768;
        2:       v = int'(dead_zone) + int'($urandom_range(0, 1));
        3:       v = -int'(dead_zone) - int'($urandom_range(0, 1));
        default: v = int'($signed(val));
      endcase
      val = 16'(v);
    end else begin
      cmd = CMD_UNUSED;
    end
    send_request(cmd, btn, axis, val);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int s = 0; s < 3; s++) begin
      random_settings();
      for (int k = 0; k < 22; k++) begin
        // hold off the sender once until the result side has caught up
        if (s == 1 && k == 10) wait_idle();
        random_request();
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    req_valid     = 1'b0;
    command       = '0;
    button_number = '0;
    axis_number   = '0;
    axis_value    = '0;
    rsp_ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    held_mask     = '0;
    map_cfg       = BUTTON_MAP_RST;
    dpad_pair     = DIGITAL_PAIR_RST;
    stick_pair    = ANALOG_PAIR_RST;
    dead_zone     = THRESHOLD_RST;
    send_idle_pct = 29;
    recv_idle_pct = 62;
    mismatches        = 0;
    requests_sent     = 0;
    events_checked    = 0;
    registers_written = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_buttons_default();
    test_direction_pad();
    test_stick_and_pad();
    test_slot_map();
    test_random_traffic(29, 62);
    test_random_traffic(62, 29);
    test_random_traffic(0, 0);

    wait_idle();
    if (expected_events.size() != 0)
      report_mismatch("events never delivered", expected_events.size(), 0);
    $display("covered %0d requests and %0d events over %0d register writes",
             requests_sent, events_checked, registers_written);
    $display("buttons, direction pad, analog stick, stalls on both channels; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("gamepad_event_translator_top verification clean");
    end else begin
      $display("gamepad_event_translator_top verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d events outstanding", expected_events.size());
    $display("gamepad_event_translator_top verification failed");
    $finish;
  end

endmodule

// File: gamepad_event_translator_top.f
sv/gevt_pkg.sv
sv/gamepad_event_translator_top.sv
test/testbench.sv
